/* rtl/c16_pkg.sv */
// c16_pkg: types, constants and small helpers for the 16-bit CPU core.
// Used by custom_16bit_cpu_core; depends on nothing else.
package c16_pkg;

  localparam int MemAddrBits = 16;
  localparam int MemDepth = 1 << MemAddrBits;

  localparam logic [15:0] StackTopReset = 16'hFFFE;
  localparam logic [15:0] StackFloorReset = 16'h0000;
  localparam logic [15:0] SyscallPortReset = 16'hFFFF;
  localparam logic [15:0] PresentCodeReset = 16'h0001;

  localparam logic [2:0] SpIdx = 3'd7;

  localparam int FlagZ = 0;
  localparam int FlagS = 1;
  localparam int FlagC = 2;

  typedef enum logic [1:0] {
    CmdWrite  = 2'd0,
    CmdRead   = 2'd1,
    CmdExec   = 2'd2,
    CmdResume = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CfgStackTop    = 2'd0,
    CfgStackFloor  = 2'd1,
    CfgSyscallPort = 2'd2,
    CfgPresentCode = 2'd3
  } cfg_e;

  typedef enum logic [4:0] {
    OpNop   = 5'h00, OpHalt  = 5'h01, OpLdiLo = 5'h02, OpLdiHi = 5'h03,
    OpLdImm = 5'h04, OpStAbs = 5'h05, OpStInd = 5'h06, OpLdInd = 5'h07,
    OpMov   = 5'h08, OpAdd   = 5'h09, OpSub   = 5'h0A, OpAnd   = 5'h0B,
    OpOr    = 5'h0C, OpXor   = 5'h0D, OpShl   = 5'h0E, OpShr   = 5'h0F,
    OpCmp   = 5'h10, OpJz    = 5'h11, OpJnz   = 5'h12, OpJs    = 5'h13,
    OpJns   = 5'h14, OpJc    = 5'h15, OpJnc   = 5'h16, OpJmp   = 5'h17,
    OpPush  = 5'h18, OpPop   = 5'h19, OpCall  = 5'h1A, OpRet   = 5'h1B,
    OpLdOff = 5'h1C, OpStOff = 5'h1D, OpMul   = 5'h1E, OpDiv   = 5'h1F
  } op_e;

  typedef enum logic [4:0] {
    StClear, StIdle, StF0, StF1, StF2, StF3, StF4, StExec,
    StLd0, StLd1, StLd2, StLdx, StPop2, StSt0, StSt1, StHook,
    StAlu, StDiv, StWb, StDone
  } state_e;

  // Replaces one byte half of a word.
  function automatic logic [15:0] set_half(logic [15:0] w, logic upper, logic [7:0] v);
    set_half = upper ? {v, w[7:0]} : {w[15:8], v};
  endfunction

  function automatic logic [7:0] get_half(logic [15:0] w, logic upper);
    get_half = upper ? w[15:8] : w[7:0];
  endfunction

endpackage

/* rtl/custom_16bit_cpu_core.sv */
// custom_16bit_cpu_core: sequenced 16-bit CPU with byte memory, register file and
// one shared ALU plus a bit-serial divider. Depends on c16_pkg.
//
//  channel | direction | signals                         | meaning
//  in      | sink      | in_valid_i / in_stall_o         | cmd_i, mem_addr_i, mem_data_i
//  out     | source    | out_valid_o / out_stall_i       | pc, flags, status, syscall, read byte
//  cfg     | sink      | cfg_we_i, cfg_idx_i, cfg_data_i | stack floor, syscall port, present code
//
// A memory write, read, resume or a step while halted passes from idle straight to the
// done state. An executed instruction's length is set by the single byte-wide memory
// port (two fetch bytes, two immediate bytes, two bytes per data word); a divide
// adds a pass through the one-bit-per-cycle divider.
// After reset the memory is cleared one byte per cycle, all 2**MemAddrBits bytes,
// while in_stall_o stays high; configuration writes are taken throughout.
// The output register holds one result; a new transaction is taken only when it
// is empty or being emptied in the same cycle.
module custom_16bit_cpu_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] mem_addr_i,
  input  logic [7:0]  mem_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] prog_counter_o,
  output logic [2:0]  flag_bits_o,
  output logic        is_running_o,
  output logic        present_pending_o,
  output logic        syscall_valid_o,
  output logic [15:0] syscall_value_o,
  output logic [7:0]  read_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import c16_pkg::*;

  state_e state_q, state_d;

  // Main memory: one byte port, registered read.
  logic [7:0]  mem [MemDepth];
  logic [7:0]  mem_q;
  logic [15:0] mem_a;
  logic        mem_we;
  logic [7:0]  mem_wd;

  // Architectural state.
  logic [15:0] rf_q [8];
  logic [15:0] pc_q, pc_d;
  logic [2:0]  flags_q, flags_d;
  logic        running_q, running_d;
  logic        present_q, present_d;
  logic        rf_we;
  logic [2:0]  rf_wa;
  logic [15:0] rf_wd;

  // Configuration. The stack top only matters at reset, where it always holds
  // its reset value, so a write to it has no lasting effect.
  logic [15:0] floor_q, port_q, code_q;

  // Per-transaction working registers.
  logic [1:0]  cmd_q, cmd_d;
  logic [15:0] ins_q, ins_d, imm_q, imm_d, a_q, a_d, b_q, b_d;
  logic [15:0] opl_q, opl_d, opr_q, opr_d, data_q, data_d, addr_q, addr_d;
  logic [31:0] res_q, res_d;
  logic        word_q, word_d, hook_q, hook_d;
  logic        sysv_q, sysv_d;
  logic [15:0] sysval_q, sysval_d;
  logic [15:0] rem_q, rem_d, quo_q, quo_d;
  logic [3:0]  dcnt_q, dcnt_d;
  logic [MemAddrBits-1:0] clr_q, clr_d;

  // Output register.
  logic        ovalid_q;
  logic [15:0] opc_q, osysval_q;
  logic [2:0]  oflags_q;
  logic        orun_q, opres_q, osysv_q;
  logic [7:0]  ord_q;

  // Instruction fields.
  op_e        op;
  logic [2:0] r1, r2;
  logic       sz, lo, mf, af;
  op_e        aop;
  logic       stack_op, accept, out_take, out_free;
  logic [15:0] next2, next4, sp_dec, base_off;
  logic [3:0]  amt;
  logic [31:0] alu_res;
  logic [16:0] trial;
  logic [2:0]  jk;
  logic        take;

  assign op = op_e'(ins_q[15:11]);
  assign r1 = ins_q[10:8];
  assign r2 = ins_q[7:5];
  assign sz = ins_q[4];
  assign lo = ins_q[3];
  assign mf = ins_q[2];
  assign af = ins_q[1];
  assign aop = (op == OpCmp) ? OpSub : op;
  assign stack_op = (op == OpPush) || (op == OpPop) || (op == OpCall) || (op == OpRet);

  assign next2 = pc_q + 16'd2;
  assign next4 = pc_q + 16'd4;
  assign sp_dec = b_q - 16'd2;
  assign base_off = b_q + imm_q;

  assign out_take = ovalid_q && !out_stall_i;
  assign out_free = !ovalid_q || !out_stall_i;
  assign in_stall_o = !((state_q == StIdle) && out_free);
  assign accept = in_valid_i && !in_stall_o;

  // Shared ALU; byte forms arrive zero-extended.
  assign amt = sz ? {1'b0, opr_q[2:0]} : opr_q[3:0];
  always_comb begin
    unique case (aop)
      OpAdd:   alu_res = 32'(opl_q) + 32'(opr_q);
      OpSub:   alu_res = 32'(opl_q) - 32'(opr_q);
      OpAnd:   alu_res = 32'(opl_q & opr_q);
      OpOr:    alu_res = 32'(opl_q | opr_q);
      OpXor:   alu_res = 32'(opl_q ^ opr_q);
      OpShl:   alu_res = 32'(opl_q) << amt;
      OpShr:   alu_res = 32'(opl_q >> amt);
      OpMul:   alu_res = 32'(opl_q) * 32'(opr_q);
      default: alu_res = 32'(opl_q);
    endcase
  end

  // One restoring-division step.
  assign trial = {rem_q, quo_q[15]};

  // Conditional jumps: pairs test zero, sign, carry; odd members invert.
  assign jk = 3'(ins_q[15:11] - 5'(OpJz));
  assign take = flags_q[jk[2:1]] ^ jk[0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (&clr_q) state_d = StIdle;
      StIdle: begin
        if (accept) begin
          if ((cmd_e'(cmd_i) == CmdExec) && running_q) state_d = StF0;
          else state_d = StDone;
        end
      end
      StF0: state_d = StF1;
      StF1: state_d = StF2;
      StF2: state_d = StF3;
      StF3: state_d = StF4;
      StF4: state_d = StExec;
      StExec: begin
        unique case (op)
          OpStAbs, OpStInd, OpPush, OpCall, OpStOff: state_d = StSt0;
          OpLdInd, OpPop, OpRet, OpLdOff: state_d = StLd0;
          OpAdd, OpSub, OpAnd, OpOr, OpXor, OpShl, OpShr, OpCmp, OpMul, OpDiv: begin
            if (!sz && lo && mf) state_d = StLd0;
            else state_d = StAlu;
          end
          default: state_d = StDone;
        endcase
      end
      StLd0: state_d = StLd1;
      StLd1: state_d = StLd2;
      StLd2: state_d = StLdx;
      StLdx: begin
        unique case (op)
          OpLdInd, OpLdOff, OpRet: state_d = StDone;
          OpPop: state_d = StPop2;
          default: state_d = StAlu;
        endcase
      end
      StPop2: state_d = StDone;
      StSt0: begin
        if (word_q) state_d = StSt1;
        else if (hook_q) state_d = StHook;
        else state_d = StDone;
      end
      StSt1: state_d = hook_q ? StHook : StDone;
      StHook: state_d = StDone;
      StAlu: state_d = ((aop == OpDiv) && (opr_q != 16'd0)) ? StDiv : StWb;
      StDiv: if (&dcnt_q) state_d = StWb;
      StWb: state_d = StDone;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    pc_d = pc_q; flags_d = flags_q; running_d = running_q; present_d = present_q;
    cmd_d = cmd_q; ins_d = ins_q; imm_d = imm_q; a_d = a_q; b_d = b_q;
    opl_d = opl_q; opr_d = opr_q; data_d = data_q; addr_d = addr_q; res_d = res_q;
    word_d = word_q; hook_d = hook_q; sysv_d = sysv_q; sysval_d = sysval_q;
    rem_d = rem_q; quo_d = quo_q; dcnt_d = dcnt_q; clr_d = clr_q;
    rf_we = 1'b0; rf_wa = r1; rf_wd = 16'd0;
    mem_a = addr_q; mem_we = 1'b0; mem_wd = 8'd0;
    unique case (state_q)
      StClear: begin
        mem_a = 16'(clr_q);
        mem_we = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      StIdle: begin
        mem_a = mem_addr_i;
        if (accept) begin
          cmd_d = cmd_i;
          sysv_d = 1'b0;
          sysval_d = 16'd0;
          if (cmd_e'(cmd_i) == CmdWrite) begin
            mem_we = 1'b1;
            mem_wd = mem_data_i;
          end
          if ((cmd_e'(cmd_i) == CmdResume) && present_q) begin
            running_d = 1'b1;
            present_d = 1'b0;
          end
        end
      end
      StF0: mem_a = pc_q;
      StF1: begin
        ins_d[7:0] = mem_q;
        mem_a = pc_q + 16'd1;
      end
      StF2: begin
        ins_d[15:8] = mem_q;
        mem_a = next2;
      end
      StF3: begin
        imm_d[7:0] = mem_q;
        mem_a = pc_q + 16'd3;
        a_d = rf_q[r1];
        b_d = rf_q[stack_op ? SpIdx : r2];
      end
      StF4: imm_d[15:8] = mem_q;
      StExec: begin
        hook_d = 1'b0;
        word_d = 1'b1;
        unique case (op)
          OpNop: pc_d = next2;
          OpHalt: begin
            running_d = 1'b0;
            pc_d = next2;
          end
          OpLdiLo, OpLdiHi: begin
            rf_we = 1'b1;
            rf_wd = set_half(a_q, op == OpLdiHi, ins_q[7:0]);
            pc_d = next2;
          end
          OpLdImm: begin
            rf_we = 1'b1;
            rf_wd = imm_q;
            pc_d = next4;
          end
          OpStAbs: begin
            addr_d = imm_q; data_d = a_q; hook_d = 1'b1; pc_d = next4;
          end
          OpStInd: begin
            addr_d = b_q;
            word_d = !sz;
            data_d = sz ? {8'd0, get_half(a_q, !lo)} : a_q;
            hook_d = 1'b1;
            pc_d = next2;
          end
          OpLdInd: begin
            addr_d = b_q; pc_d = next2;
          end
          OpMov: begin
            rf_we = 1'b1;
            rf_wd = sz ? set_half(a_q, !lo, get_half(b_q, !lo)) : b_q;
            pc_d = next2;
          end
          OpAdd, OpSub, OpAnd, OpOr, OpXor, OpShl, OpShr, OpCmp, OpMul, OpDiv: begin
            if (sz) begin
              opl_d = {8'd0, get_half(a_q, !lo)};
              opr_d = {8'd0, get_half(b_q, !lo)};
            end else begin
              opl_d = a_q;
              opr_d = lo ? b_q : imm_q;
              addr_d = af ? imm_q : base_off;
            end
          end
          OpJz, OpJnz, OpJs, OpJns, OpJc, OpJnc: pc_d = take ? imm_q : next4;
          OpJmp: pc_d = lo ? a_q : imm_q;
          OpPush: begin
            rf_we = 1'b1; rf_wa = SpIdx; rf_wd = sp_dec;
            addr_d = sp_dec;
            data_d = (r1 == SpIdx) ? sp_dec : a_q;
            pc_d = next2;
          end
          OpPop, OpRet: addr_d = b_q;
          OpCall: begin
            rf_we = 1'b1; rf_wa = SpIdx; rf_wd = sp_dec;
            addr_d = sp_dec; data_d = next4; pc_d = imm_q;
          end
          OpLdOff: begin
            addr_d = af ? imm_q : base_off; pc_d = next4;
          end
          OpStOff: begin
            addr_d = base_off; data_d = a_q; hook_d = 1'b1; pc_d = next4;
          end
          default: ;
        endcase
      end
      StLd0: mem_a = addr_q;
      StLd1: begin
        data_d[7:0] = mem_q;
        mem_a = addr_q + 16'd1;
      end
      StLd2: data_d[15:8] = mem_q;
      StLdx: begin
        unique case (op)
          OpLdInd: begin
            rf_we = 1'b1;
            rf_wd = sz ? set_half(a_q, !lo, data_q[7:0]) : data_q;
          end
          OpLdOff: begin
            rf_we = 1'b1; rf_wd = data_q;
          end
          OpPop: begin
            rf_we = 1'b1; rf_wd = data_q;
            addr_d = ((r1 == SpIdx) ? data_q : b_q) + 16'd2;
          end
          OpRet: begin
            rf_we = 1'b1; rf_wa = SpIdx; rf_wd = b_q + 16'd2;
            pc_d = data_q;
          end
          default: opr_d = data_q;
        endcase
      end
      StPop2: begin
        rf_we = 1'b1; rf_wa = SpIdx; rf_wd = addr_q;
        if (addr_q < floor_q) running_d = 1'b0;
        else pc_d = next2;
      end
      StSt0: begin
        mem_a = addr_q; mem_we = 1'b1; mem_wd = data_q[7:0];
      end
      StSt1: begin
        mem_a = addr_q + 16'd1; mem_we = 1'b1; mem_wd = data_q[15:8];
      end
      StHook: begin
        if (addr_q == port_q) begin
          if (data_q == code_q) begin
            present_d = 1'b1;
            running_d = 1'b0;
          end else begin
            sysv_d = 1'b1;
            sysval_d = data_q;
          end
        end
      end
      StAlu: begin
        res_d = alu_res;
        if (aop == OpDiv) begin
          res_d = sz ? 32'h0000_00FF : 32'h0000_FFFF;
          rem_d = 16'd0;
          quo_d = opl_q;
          dcnt_d = 4'd0;
        end
      end
      StDiv: begin
        if (trial >= {1'b0, opr_q}) begin
          rem_d = 16'(trial - {1'b0, opr_q});
          quo_d = {quo_q[14:0], 1'b1};
        end else begin
          rem_d = trial[15:0];
          quo_d = {quo_q[14:0], 1'b0};
        end
        dcnt_d = dcnt_q + 4'd1;
        res_d = {16'd0, quo_d};
      end
      StWb: begin
        flags_d[FlagZ] = (res_q[15:0] == 16'd0);
        flags_d[FlagS] = res_q[15];
        flags_d[FlagC] = |res_q[31:16];
        if (op != OpCmp) begin
          rf_we = 1'b1;
          rf_wd = sz ? set_half(a_q, !lo, res_q[7:0]) : res_q[15:0];
        end
        pc_d = (!sz && (!lo || mf)) ? next4 : next2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_a[MemAddrBits-1:0]] <= mem_wd;
    mem_q <= mem[mem_a[MemAddrBits-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) rf_q[i] <= (3'(i) == SpIdx) ? StackTopReset : 16'd0;
    end else if (rf_we) begin
      rf_q[rf_wa] <= rf_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      pc_q <= 16'd0;
      flags_q <= 3'd0;
      running_q <= 1'b1;
      present_q <= 1'b0;
      floor_q <= StackFloorReset;
      port_q <= SyscallPortReset;
      code_q <= PresentCodeReset;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      pc_q <= pc_d;
      flags_q <= flags_d;
      running_q <= running_d;
      present_q <= present_d;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CfgStackTop: ;
          CfgStackFloor: floor_q <= cfg_data_i;
          CfgSyscallPort: port_q <= cfg_data_i;
          CfgPresentCode: code_q <= cfg_data_i;
        endcase
      end
      if (state_q == StDone) ovalid_q <= 1'b1;
      else if (out_take) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; ins_q <= ins_d; imm_q <= imm_d; a_q <= a_d; b_q <= b_d;
    opl_q <= opl_d; opr_q <= opr_d; data_q <= data_d; addr_q <= addr_d;
    res_q <= res_d; word_q <= word_d; hook_q <= hook_d;
    sysv_q <= sysv_d; sysval_q <= sysval_d;
    rem_q <= rem_d; quo_q <= quo_d; dcnt_q <= dcnt_d;
    if (state_q == StDone) begin
      opc_q <= pc_q;
      oflags_q <= flags_q;
      orun_q <= running_q;
      opres_q <= present_q;
      osysv_q <= sysv_q;
      osysval_q <= sysval_q;
      ord_q <= (cmd_e'(cmd_q) == CmdRead) ? mem_q : 8'd0;
    end
  end

  assign out_valid_o = ovalid_q;
  assign prog_counter_o = opc_q;
  assign flag_bits_o = oflags_q;
  assign is_running_o = orun_q;
  assign present_pending_o = opres_q;
  assign syscall_valid_o = osysv_q;
  assign syscall_value_o = osysval_q;
  assign read_data_o = ord_q;

`ifndef SYNTHESIS
  // A result is only produced into an output register that is empty or being emptied.
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> !ovalid_q || !out_stall_i)
    else $error("result overwrote a pending output");
  // No transaction is accepted while the memory is being cleared.
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> in_stall_o && !ovalid_q)
    else $error("activity during memory clear");
  // A pending present yield always leaves the core stopped.
  a_present_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    present_q |-> !running_q)
    else $error("present pending while running");
  // The divider leaves only after all sixteen steps.
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) && !(&dcnt_q) |=> (state_q == StDiv))
    else $error("divider left early");
`endif

endmodule
